// File: design/scsp_pkg.sv
package scsp_pkg;

    // Default parameter values.
    localparam int CMD_LEN_DEF   = 10;
    localparam int MOTOR_CNT_DEF = 4;

    // Queue between the front and the back.
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    // Reset values of the configuration registers and the motor positions, and the timeout ceiling.
    localparam logic [15:0] PWM_PERIOD_RST  = 16'd2000;
    localparam logic [15:0] SLOW_DIV_RST    = 16'd10000;
    localparam logic [15:0] CMD_TIMEOUT_RST = 16'd100;
    localparam logic [7:0]  MOTOR_POS_RST   = 8'd25;
    localparam logic [15:0] TIMEOUT_MAX     = 16'hFFFF;

    // Characters of the command language.
    localparam logic [7:0] CH_AT   = 8'h40;
    localparam logic [7:0] CH_HASH = 8'h23;
    localparam logic [7:0] CH_S    = 8'h53;
    localparam logic [7:0] CH_M    = 8'h4D;
    localparam logic [7:0] CH_0    = 8'h30;
    localparam logic [7:0] CH_1    = 8'h31;
    localparam logic [7:0] CH_9    = 8'h39;
    localparam logic [7:0] CH_A    = 8'h41;
    localparam logic [7:0] CH_F    = 8'h46;

    typedef enum logic [1:0] {
        REG_PWM_PERIOD  = 2'd0,
        REG_SLOW_DIV    = 2'd1,
        REG_CMD_TIMEOUT = 2'd2
    } t_reg_idx;

    typedef struct packed {
        logic [15:0] pwm_period;
        logic [15:0] slow_div;
        logic [15:0] cmd_timeout;
    } t_cfg;

    // A request after classification by the front.
    typedef struct packed {
        logic       is_tick;
        logic       is_at;
        logic       is_hash;
        logic [7:0] data;
    } t_item;

    typedef enum logic {
        MODE_SCAN,
        MODE_BUILD
    } t_mode;

    typedef struct packed {
        logic       ok;
        logic [3:0] val;
    } t_hex;

    // Upper-case hexadecimal digit decode.
    function automatic t_hex hex_decode(input logic [7:0] c);
        t_hex h;
        h.ok  = 1'b0;
        h.val = 4'd0;
        if (c >= CH_0 && c <= CH_9) begin
            h.ok  = 1'b1;
            h.val = c[3:0];
        end else if (c >= CH_A && c <= CH_F) begin
            h.ok  = 1'b1;
            h.val = 4'(c - (CH_A - 8'd10));
        end
        return h;
    endfunction

endpackage

// File: design/scsp_if.sv
interface scsp_in_if;
    logic       valid;
    logic       ready;
    logic       op;
    logic [7:0] rx_byte;

    modport source (output valid, output op, output rx_byte, input ready);
    modport sink   (input valid, input op, input rx_byte, output ready);
endinterface

interface scsp_out_if;
    logic       valid;
    logic       ready;
    logic       echo_valid;
    logic [7:0] echo_byte;
    logic       pwm_first;
    logic       pwm_second;
    logic       health_led;

    modport source (output valid, output echo_valid, output echo_byte, output pwm_first,
                    output pwm_second, output health_led, input ready);
    modport sink   (input valid, input echo_valid, input echo_byte, input pwm_first,
                    input pwm_second, input health_led, output ready);
endinterface

// File: design/scsp_front.sv
module scsp_front
    import scsp_pkg::*;
(
    scsp_in_if.sink i_in,
    output logic    o_push_valid,
    output t_item   o_push_item,
    input  logic    i_push_ready
);

    // Classify the request so the back only looks at flags.
    always_comb begin
        o_push_item.is_tick = i_in.op;
        o_push_item.is_at   = !i_in.op && (i_in.rx_byte == CH_AT);
        o_push_item.is_hash = !i_in.op && (i_in.rx_byte == CH_HASH);
        o_push_item.data    = i_in.rx_byte;
    end

    assign o_push_valid = i_in.valid;
    assign i_in.ready   = i_push_ready;

endmodule

// File: design/scsp_queue.sv
module scsp_queue
    import scsp_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push_valid,
    input  t_item i_push_item,
    output logic  o_push_ready,
    output logic  o_pop_valid,
    output t_item o_pop_item,
    input  logic  i_pop
);

    t_item               r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wr_ptr;
    logic [QUEUE_AW-1:0] r_rd_ptr;
    logic [QUEUE_AW:0]   r_count;
    logic                push;
    logic                pop;

    assign o_push_ready = (r_count != (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_item   = r_mem[r_rd_ptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = i_pop && o_pop_valid;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// File: design/scsp_back.sv
module scsp_back
    import scsp_pkg::*;
#(
    parameter int COMMAND_LENGTH = CMD_LEN_DEF,
    parameter int MOTOR_COUNT    = MOTOR_CNT_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cfg        i_cfg,
    input  logic        i_q_valid,
    input  t_item       i_item,
    output logic        o_pop,
    scsp_out_if.source  o_out
);

    localparam int FILL_W = $clog2(COMMAND_LENGTH + 1);
    localparam int IDX_W  = $clog2(COMMAND_LENGTH);
    localparam int MIDX_W = $clog2(MOTOR_COUNT);
    localparam logic [7:0] CH_LAST_MOTOR = 8'(CH_0 + MOTOR_COUNT);

    t_mode             r_mode, n_mode;
    logic [15:0]       r_pwm_cnt, n_pwm_cnt;
    logic [15:0]       r_fast, n_fast;
    logic [15:0]       r_tout, n_tout;
    logic [FILL_W-1:0] r_fill, n_fill;
    logic [7:0]        r_store [COMMAND_LENGTH];
    logic [7:0]        n_store [COMMAND_LENGTH];
    logic [7:0]        r_motor [MOTOR_COUNT];
    logic [7:0]        n_motor [MOTOR_COUNT];
    logic              r_first, n_first;
    logic              r_second, n_second;
    logic              r_led, n_led;
    logic              r_out_valid;
    logic              r_echo_valid, n_echo_valid;
    logic [7:0]        r_echo_byte, n_echo_byte;

    logic              cmd_ok;
    logic [MIDX_W-1:0] cmd_motor;
    t_hex              hex_hi;
    logic [15:0]       fast_inc;
    t_hex              hex_lo;
    logic [15:0]       tout_inc;

    // The back takes the next request whenever the result slot is free or drains now.
    assign o_pop = i_q_valid && (!r_out_valid || o_out.ready);

    // Decode of a stored "SM<n><hex><hex>" command.
    always_comb begin
        hex_hi    = hex_decode(r_store[3]);
        hex_lo    = hex_decode(r_store[4]);
        cmd_motor = MIDX_W'(r_store[2] - CH_1);
        cmd_ok    = (r_store[0] == CH_S) && (r_store[1] == CH_M) &&
                    (r_store[2] >= CH_1) && (r_store[2] <= CH_LAST_MOTOR) &&
                    hex_hi.ok && hex_lo.ok;
    end

    always_comb begin
        n_mode       = r_mode;
        n_pwm_cnt    = r_pwm_cnt;
        n_fast       = r_fast;
        n_tout       = r_tout;
        n_fill       = r_fill;
        n_store      = r_store;
        n_motor      = r_motor;
        n_first      = r_first;
        n_second     = r_second;
        n_led        = r_led;
        n_echo_valid = 1'b0;
        n_echo_byte  = 8'd0;
        fast_inc     = r_fast + 16'd1;
        tout_inc     = (r_tout == TIMEOUT_MAX) ? r_tout : r_tout + 16'd1;

        if (i_item.is_tick) begin
            if (r_pwm_cnt == 16'd0) begin
                n_first  = 1'b1;
                n_second = 1'b1;
            end else begin
                if (r_pwm_cnt == {8'd0, r_motor[0]}) begin
                    n_first = 1'b0;
                end
                if (r_pwm_cnt == {8'd0, r_motor[1]}) begin
                    n_second = 1'b0;
                end
            end
            n_pwm_cnt = (r_pwm_cnt == i_cfg.pwm_period) ? 16'd0 : r_pwm_cnt + 16'd1;

            if (fast_inc >= i_cfg.slow_div) begin
                n_fast = 16'd0;
                n_led  = !r_led;
                n_tout = tout_inc;
                if (tout_inc > i_cfg.cmd_timeout) begin
                    n_mode = MODE_SCAN;
                end
            end else begin
                n_fast = fast_inc;
            end
        end else begin
            unique case (r_mode)
                MODE_SCAN: begin
                    n_echo_valid = 1'b1;
                    n_echo_byte  = i_item.data;
                    if (i_item.is_at) begin
                        n_mode = MODE_BUILD;
                        n_tout = 16'd0;
                        n_fill = '0;
                    end
                end
                MODE_BUILD: begin
                    if (i_item.is_hash) begin
                        n_mode = MODE_SCAN;
                        if (cmd_ok) begin
                            n_motor[cmd_motor] = {hex_hi.val, hex_lo.val};
                        end
                    end else if (r_fill < FILL_W'(COMMAND_LENGTH)) begin
                        n_store[r_fill[IDX_W-1:0]] = i_item.data;
                        n_fill = r_fill + 1'b1;
                    end else begin
                        // Overlong command: drop the byte and go back to scanning.
                        n_mode = MODE_SCAN;
                    end
                end
                default: begin
                    n_mode = MODE_SCAN;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_SCAN;
            r_pwm_cnt   <= '0;
            r_fast      <= '0;
            r_tout      <= '0;
            r_fill      <= '0;
            r_first     <= 1'b0;
            r_second    <= 1'b0;
            r_led       <= 1'b0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < COMMAND_LENGTH; i++) begin
                r_store[i] <= 8'd0;
            end
            for (int i = 0; i < MOTOR_COUNT; i++) begin
                r_motor[i] <= (i < 2) ? MOTOR_POS_RST : 8'd0;
            end
        end else begin
            if (o_pop) begin
                r_mode      <= n_mode;
                r_pwm_cnt   <= n_pwm_cnt;
                r_fast      <= n_fast;
                r_tout      <= n_tout;
                r_fill      <= n_fill;
                r_store     <= n_store;
                r_motor     <= n_motor;
                r_first     <= n_first;
                r_second    <= n_second;
                r_led       <= n_led;
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_echo_valid <= n_echo_valid;
            r_echo_byte  <= n_echo_byte;
        end
    end

    // Levels only move when a request is taken, which needs a free result slot,
    // so the live level registers always match the waiting result.
    assign o_out.valid      = r_out_valid;
    assign o_out.echo_valid = r_echo_valid;
    assign o_out.echo_byte  = r_echo_byte;
    assign o_out.pwm_first  = r_first;
    assign o_out.pwm_second = r_second;
    assign o_out.health_led = r_led;

endmodule

// File: design/serial_command_servo_pwm_core.sv
// An accepted request is written into the queue; the back end then pops it into its result register.
// The back end takes one request per cycle while its result slot is free or draining (o_out.ready).
// A four-entry queue between front and back lets the input keep flowing while a result waits.
// Reset (i_rst_n low, synchronous) empties the queue, drops any pending result, returns
// the parser to scan mode, clears counters, levels and the command store, sets motors
// one and two to 25, and loads the configuration defaults 2000, 10000 and 100.
module serial_command_servo_pwm_core
    import scsp_pkg::*;
#(
    parameter int COMMAND_LENGTH = CMD_LEN_DEF,
    parameter int MOTOR_COUNT    = MOTOR_CNT_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    scsp_in_if.sink     i_in,
    scsp_out_if.source  o_out
);

    t_cfg  r_cfg;
    logic  push_valid;
    logic  push_ready;
    t_item push_item;
    logic  pop_valid;
    t_item pop_item;
    logic  pop;

    // Configuration registers. Writes must come only while the block is idle; the block does
    // not enforce this; the back end reads them directly. Writes to an unused index are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pwm_period  <= PWM_PERIOD_RST;
            r_cfg.slow_div    <= SLOW_DIV_RST;
            r_cfg.cmd_timeout <= CMD_TIMEOUT_RST;
        end else if (i_cfg_we) begin
            unique case (t_reg_idx'(i_cfg_idx))
                REG_PWM_PERIOD:  r_cfg.pwm_period  <= i_cfg_data;
                REG_SLOW_DIV:    r_cfg.slow_div    <= i_cfg_data;
                REG_CMD_TIMEOUT: r_cfg.cmd_timeout <= i_cfg_data;
                default: begin
                    r_cfg <= r_cfg;
                end
            endcase
        end
    end

    // The front classifies each request (tick, '@', '#', plain byte).
    scsp_front u_front (
        .i_in         (i_in),
        .o_push_valid (push_valid),
        .o_push_item  (push_item),
        .i_push_ready (push_ready)
    );

    // The queue decouples acceptance from execution.
    scsp_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .i_push_item  (push_item),
        .o_push_ready (push_ready),
        .o_pop_valid  (pop_valid),
        .o_pop_item   (pop_item),
        .i_pop        (pop)
    );

    // The back runs the parser, the PWM counter and the slow divider, and holds
    // the result register.
    scsp_back #(
        .COMMAND_LENGTH (COMMAND_LENGTH),
        .MOTOR_COUNT    (MOTOR_COUNT)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_q_valid (pop_valid),
        .i_item    (pop_item),
        .o_pop     (pop),
        .o_out     (o_out)
    );

endmodule
